// ----- rtl/core/line_pixel_generator_unit_macros.svh -----
// Assertion helpers shared by the files that check their own logic.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef LINE_PIXEL_GENERATOR_UNIT_MACROS_SVH
`define LINE_PIXEL_GENERATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPG_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line pixel generator check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line pixel generator check failed");

`endif

// ----- rtl/core/lpg_pkg.sv -----
package lpg_pkg;

	localparam int COLOR_BITS = 24;

	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	typedef enum logic [1:0] {
		MODE_DIAG    = 2'd0,
		MODE_VERT    = 2'd1,
		MODE_HORZ    = 2'd2,
		MODE_GENERAL = 2'd3
	} line_mode_t;

endpackage

// ----- rtl/core/lpg_out_buf.sv -----
module lpg_out_buf #(
	parameter int DATA_BITS = 49
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  logic [DATA_BITS-1:0] wr_data,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output logic [DATA_BITS-1:0] rd_data
);

	logic                 main_valid_q;
	logic [DATA_BITS-1:0] main_data_q;
	logic                 skid_valid_q;
	logic [DATA_BITS-1:0] skid_data_q;
	logic                 main_free;

	// A transaction can be taken as long as the skid slot is empty.
	assign wr_ready  = !skid_valid_q;
	assign rd_valid  = main_valid_q;
	assign rd_data   = main_data_q;
	assign main_free = !main_valid_q || rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (main_free) begin
				if (skid_valid_q) begin
					main_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= wr_valid;
				end
			end else if (wr_valid && !skid_valid_q) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_data_q <= skid_valid_q ? skid_data_q : wr_data;
		end
		if (!main_free && wr_valid && !skid_valid_q) begin
			skid_data_q <= wr_data;
		end
	end

endmodule

// ----- rtl/core/line_pixel_generator_unit.sv -----
// Line pixel generator: rasterizes one line segment, at most one pixel per transaction.
// Input channel (in_valid/in_ready): action = start loads both endpoints and the
// color and produces the first pixel; action = advance produces the next pixel.
// An advance with no line in progress produces nothing. A start during a line
// abandons the old line at once.
// Output channel (out_valid/out_ready): pixel_x, pixel_y, pixel_color and last,
// which marks the final pixel of the line. Every line gives max(|dx|,|dy|)+1
// pixels; in the general (non-axis, non-diagonal) case the far endpoint comes
// first.
// Each pixel is registered: it goes into the output register, or into the skid
// slot while the receiver stalls. Throughput: one transaction per cycle while
// in_ready is high, set by the combinational step update feeding the buffer.
// A two-entry output buffer (output register plus skid slot) lets one more
// transaction in while the receiver stalls; in_ready drops once both entries
// hold pixels and rises again when the receiver takes one.
// Reset clears all line state: the block comes up idle with no pixel pending.
module line_pixel_generator_unit #(
	parameter int COORD_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic signed [COORD_BITS-1:0]    x_start,
	input  logic signed [COORD_BITS-1:0]    y_start,
	input  logic signed [COORD_BITS-1:0]    x_stop,
	input  logic signed [COORD_BITS-1:0]    y_stop,
	input  logic [lpg_pkg::COLOR_BITS-1:0]  line_color,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [COORD_BITS-1:0]    pixel_x,
	output logic signed [COORD_BITS-1:0]    pixel_y,
	output logic [lpg_pkg::COLOR_BITS-1:0]  pixel_color,
	output logic                            last
);

	import lpg_pkg::*;

	`include "line_pixel_generator_unit_macros.svh"

	localparam int C      = COORD_BITS;
	localparam int E      = COORD_BITS + 2;
	localparam int PIX_W  = 2 * COORD_BITS + COLOR_BITS + 1;

	// Line state.
	logic signed [C-1:0]   cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic [C-1:0]          run_dx_q, run_dy_q;
	logic signed [E-1:0]   err_acc_q;
	logic                  x_dir_neg_q, y_dir_neg_q, transposed_q, busy_q;
	line_mode_t            line_mode_q;
	logic [COLOR_BITS-1:0] held_color_q;

	logic signed [C-1:0]   cur_x_d, cur_y_d, end_x_d, end_y_d;
	logic [C-1:0]          run_dx_d, run_dy_d;
	logic signed [E-1:0]   err_acc_d;
	logic                  x_dir_neg_d, y_dir_neg_d, transposed_d, busy_d;
	line_mode_t            line_mode_d;
	logic [COLOR_BITS-1:0] held_color_d;

	// Pixel produced by this transaction.
	logic                  res_valid;
	logic signed [C-1:0]   res_x, res_y;
	logic [COLOR_BITS-1:0] res_color;
	logic                  res_last;

	logic                  in_acc;
	logic                  res_wr;
	logic [PIX_W-1:0]      res_data, out_data;

	// Start-path signals.
	logic signed [C:0]     dxs, dys;
	logic [C-1:0]          adx, ady, maj, mnr;
	logic                  steep;
	logic signed [C-1:0]   gx0, gy0, gx1, gy1, nx, ny, fx, fy;

	// Advance-path signals.
	logic signed [C:0]     cx_ext, cx_inc, ex_ext;
	logic                  gen_fin, axis_fin;
	logic signed [C-1:0]   ax_x, ax_y, step_x, step_y, gen_y;
	logic signed [E-1:0]   two_dx, two_dy, err_mid;

	assign in_acc = in_valid && in_ready;
	assign res_wr = in_acc && res_valid;

	always_comb begin
		dxs   = {x_stop[C-1], x_stop} - {x_start[C-1], x_start};
		dys   = {y_stop[C-1], y_stop} - {y_start[C-1], y_start};
		adx   = dxs[C] ? C'(-dxs) : dxs[C-1:0];
		ady   = dys[C] ? C'(-dys) : dys[C-1:0];
		steep = adx < ady;
		maj   = steep ? ady : adx;
		mnr   = steep ? adx : ady;
		gx0   = steep ? y_start : x_start;
		gy0   = steep ? x_start : y_start;
		gx1   = steep ? y_stop  : x_stop;
		gy1   = steep ? x_stop  : y_stop;
		// Order the endpoints by increasing major coordinate.
		if (gx0 > gx1) begin
			nx = gx1; ny = gy1; fx = gx0; fy = gy0;
		end else begin
			nx = gx0; ny = gy0; fx = gx1; fy = gy1;
		end

		step_x = x_dir_neg_q ? -C'(1) : C'(1);
		step_y = y_dir_neg_q ? -C'(1) : C'(1);
		ax_x   = (cur_x_q != end_x_q) ? cur_x_q + step_x : cur_x_q;
		ax_y   = (cur_y_q != end_y_q) ? cur_y_q + step_y : cur_y_q;
		axis_fin = (ax_x == end_x_q) && (ax_y == end_y_q);

		cx_ext  = {cur_x_q[C-1], cur_x_q};
		ex_ext  = {end_x_q[C-1], end_x_q};
		cx_inc  = cx_ext + $signed((C+1)'(1));
		gen_fin = cx_inc >= ex_ext;
		two_dx  = $signed({1'b0, run_dx_q, 1'b0});
		two_dy  = $signed({1'b0, run_dy_q, 1'b0});
		err_mid = err_acc_q[E-1] ? err_acc_q : err_acc_q - two_dx;
		gen_y   = err_acc_q[E-1] ? cur_y_q : cur_y_q + step_y;
	end

	always_comb begin
		cur_x_d      = cur_x_q;
		cur_y_d      = cur_y_q;
		end_x_d      = end_x_q;
		end_y_d      = end_y_q;
		run_dx_d     = run_dx_q;
		run_dy_d     = run_dy_q;
		err_acc_d    = err_acc_q;
		x_dir_neg_d  = x_dir_neg_q;
		y_dir_neg_d  = y_dir_neg_q;
		transposed_d = transposed_q;
		line_mode_d  = line_mode_q;
		busy_d       = busy_q;
		held_color_d = held_color_q;
		res_valid    = 1'b0;
		res_x        = cur_x_q;
		res_y        = cur_y_q;
		res_color    = held_color_q;
		res_last     = 1'b0;

		case (action)
			ACT_START: begin
				held_color_d = line_color;
				res_color    = line_color;
				res_valid    = 1'b1;
				if (adx == ady || adx == '0 || ady == '0) begin
					if (adx == ady) begin
						line_mode_d = MODE_DIAG;
					end else if (adx == '0) begin
						line_mode_d = MODE_VERT;
					end else begin
						line_mode_d = MODE_HORZ;
					end
					transposed_d = 1'b0;
					err_acc_d    = '0;
					cur_x_d      = x_start;
					cur_y_d      = y_start;
					end_x_d      = x_stop;
					end_y_d      = y_stop;
					x_dir_neg_d  = x_stop < x_start;
					y_dir_neg_d  = y_stop < y_start;
					run_dx_d     = adx;
					run_dy_d     = ady;
					res_x        = x_start;
					res_y        = y_start;
					res_last     = (adx == '0) && (ady == '0);
					busy_d       = !res_last;
				end else begin
					line_mode_d  = MODE_GENERAL;
					transposed_d = steep;
					x_dir_neg_d  = 1'b0;
					y_dir_neg_d  = fy < ny;
					cur_x_d      = nx;
					cur_y_d      = ny;
					end_x_d      = fx;
					end_y_d      = fy;
					run_dx_d     = maj;
					run_dy_d     = mnr;
					err_acc_d    = $signed({1'b0, mnr, 1'b0}) - $signed({2'b00, maj});
					busy_d       = 1'b1;
					// The far endpoint goes out first, in screen orientation.
					res_x        = steep ? fy : fx;
					res_y        = steep ? fx : fy;
					res_last     = 1'b0;
				end
			end
			ACT_ADVANCE: begin
				if (busy_q) begin
					res_valid = 1'b1;
					if (line_mode_q != MODE_GENERAL) begin
						cur_x_d  = ax_x;
						cur_y_d  = ax_y;
						res_x    = ax_x;
						res_y    = ax_y;
						res_last = axis_fin;
						busy_d   = !axis_fin;
					end else begin
						res_x     = transposed_q ? cur_y_q : cur_x_q;
						res_y     = transposed_q ? cur_x_q : cur_y_q;
						res_last  = gen_fin;
						cur_y_d   = gen_y;
						err_acc_d = err_mid + two_dy;
						cur_x_d   = cx_inc[C-1:0];
						busy_d    = !gen_fin;
					end
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			end_x_q      <= '0;
			end_y_q      <= '0;
			run_dx_q     <= '0;
			run_dy_q     <= '0;
			err_acc_q    <= '0;
			x_dir_neg_q  <= 1'b0;
			y_dir_neg_q  <= 1'b0;
			transposed_q <= 1'b0;
			line_mode_q  <= MODE_DIAG;
			busy_q       <= 1'b0;
			held_color_q <= '0;
		end else if (in_acc) begin
			cur_x_q      <= cur_x_d;
			cur_y_q      <= cur_y_d;
			end_x_q      <= end_x_d;
			end_y_q      <= end_y_d;
			run_dx_q     <= run_dx_d;
			run_dy_q     <= run_dy_d;
			err_acc_q    <= err_acc_d;
			x_dir_neg_q  <= x_dir_neg_d;
			y_dir_neg_q  <= y_dir_neg_d;
			transposed_q <= transposed_d;
			line_mode_q  <= line_mode_d;
			busy_q       <= busy_d;
			held_color_q <= held_color_d;
		end
	end

	assign res_data = {res_x, res_y, res_color, res_last};

	lpg_out_buf #(
		.DATA_BITS (PIX_W)
	) u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (res_wr),
		.wr_ready (in_ready),
		.wr_data  (res_data),
		.rd_valid (out_valid),
		.rd_ready (out_ready),
		.rd_data  (out_data)
	);

	assign pixel_x     = out_data[PIX_W-1 -: C];
	assign pixel_y     = out_data[PIX_W-C-1 -: C];
	assign pixel_color = out_data[COLOR_BITS:1];
	assign last        = out_data[0];

	// A start transaction always leaves a pixel on the output.
	`LPG_ASSERT_NEXT(a_start_gives_pixel, in_acc && action == ACT_START, out_valid)
	// A general walk always stays short of the far major coordinate.
	`LPG_ASSERT_SAME(a_general_before_end, busy_q && line_mode_q == MODE_GENERAL,
		cur_x_q < end_x_q)
	// An axis or diagonal line in progress has not yet reached its end.
	`LPG_ASSERT_SAME(a_axis_not_at_end, busy_q && line_mode_q != MODE_GENERAL,
		cur_x_q != end_x_q || cur_y_q != end_y_q)
	// Back-pressure only appears when a pixel is waiting at the output.
	`LPG_ASSERT_SAME(a_stall_has_pixel, !in_ready, out_valid)

endmodule
